[src/pfsd_pkg.sv]
// shared types and constants for the protobuf field stream decoder
package pfsd_pkg;

  localparam int unsigned MAX_PAYLOAD = 512;
  localparam int unsigned POS_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int unsigned RES_W   = 54;
  localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [2:0]  WIRE_VARINT  = 3'd0;
  localparam logic [2:0]  WIRE_LEN     = 3'd2;
  localparam logic [4:0]  FIELD_FIRST  = 5'd1;
  localparam logic [4:0]  FIELD_SECOND = 5'd2;
  localparam logic [5:0]  SHIFT_LIMIT  = 6'd32;
  localparam logic [5:0]  SHIFT_STEP   = 6'd7;
  localparam logic [31:0] LEN_SAT      = 32'd1023;

  typedef enum logic [2:0] {
    PH_TAG    = 3'b001,
    PH_VARINT = 3'b010,
    PH_SKIP   = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_WIRE = 2'd1,
    ST_OVERRUN  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef struct packed {
    phase_e             phase;
    logic [31:0]        accum;
    logic [5:0]         shift;
    logic               is_len;
    logic               is_f1;
    logic               is_f2;
    logic [POS_W-1:0]   pos;
    logic [31:0]        skip;
    logic [31:0]        first;
    logic [8:0]         sec_off;
    logic [9:0]         sec_len;
    logic               sec_flag;
    status_e            err;
  } parse_state_t;

  typedef struct packed {
    logic [9:0]  second_length;
    logic [8:0]  second_offset;
    logic        second_present;
    logic [31:0] first_value;
    status_e     status;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:    PH_TAG,
    accum:    32'd0,
    shift:    6'd0,
    is_len:   1'b0,
    is_f1:    1'b0,
    is_f2:    1'b0,
    pos:      '0,
    skip:     32'd0,
    first:    32'd0,
    sec_off:  9'd0,
    sec_len:  10'd0,
    sec_flag: 1'b0,
    err:      ST_OK
  };

endpackage

[src/pfsd_core.sv]
// next-state and result logic for one payload beat
module pfsd_core import pfsd_pkg::*; (
  input  parse_state_t state_i,
  input  logic [7:0]   byte_i,
  input  logic         has_i,
  input  logic         last_i,
  output parse_state_t state_o,
  output result_t      result_o
);

  function automatic parse_state_t finish_varint(parse_state_t s, logic at_end);
    logic [31:0] v;
    v       = s.accum;
    s.accum = 32'd0;
    s.shift = 6'd0;
    s.phase = PH_TAG;
    if (!s.is_len) begin
      if (s.is_f1) s.first = v;
    end else if (at_end && (v != 32'd0)) begin
      s.err = ST_OVERRUN;
    end else begin
      if (s.is_f2) begin
        s.sec_flag = 1'b1;
        s.sec_off  = 9'(s.pos);
        s.sec_len  = (v > LEN_SAT) ? LEN_SAT[9:0] : v[9:0];
      end
      if (v != 32'd0) begin
        s.skip  = v;
        s.phase = PH_SKIP;
      end
    end
    return s;
  endfunction

  parse_state_t n;

  always_comb begin
    n = state_i;
    if (has_i && (n.err == ST_OK)) begin
      if (n.pos >= POS_W'(MAX_PAYLOAD)) begin
        n.err = ST_TOO_LONG;
      end else begin
        n.pos = n.pos + POS_W'(1);
        unique case (n.phase)
          PH_VARINT: begin
            if (n.shift < SHIFT_LIMIT) begin
              n.accum = n.accum | ({25'd0, byte_i[6:0]} << n.shift);
            end
            if (!byte_i[7]) begin
              n = finish_varint(n, 1'b0);
            end else if (n.shift < SHIFT_LIMIT) begin
              n.shift = n.shift + SHIFT_STEP;
            end
          end
          PH_SKIP: begin
            n.skip = n.skip - 32'd1;
            if (n.skip == 32'd0) n.phase = PH_TAG;
          end
          default: begin
            // tag byte
            n.is_f1 = (byte_i[7:3] == FIELD_FIRST);
            n.is_f2 = (byte_i[7:3] == FIELD_SECOND);
            if ((byte_i[2:0] != WIRE_VARINT) && (byte_i[2:0] != WIRE_LEN)) begin
              n.err = ST_BAD_WIRE;
            end else begin
              n.is_len = (byte_i[2:0] == WIRE_LEN);
              n.accum  = 32'd0;
              n.shift  = 6'd0;
              n.phase  = PH_VARINT;
            end
          end
        endcase
      end
    end

    // close out whatever is pending at the end of the frame
    if (last_i && (n.err == ST_OK)) begin
      if (n.phase == PH_VARINT) begin
        n = finish_varint(n, 1'b1);
      end else if ((n.phase == PH_SKIP) && (n.skip != 32'd0)) begin
        n.err = ST_OVERRUN;
      end
    end

    result_o.status         = n.err;
    result_o.first_value    = n.first;
    result_o.second_present = n.sec_flag;
    result_o.second_offset  = n.sec_off;
    result_o.second_length  = n.sec_len;

    state_o = last_i ? STATE_RESET : n;
  end

endmodule

[src/protobuf_field_stream_decoder_unit.sv]
// top level of the protobuf field stream decoder
//
// slave channel: one payload byte per beat in s_axis_tdata_i, s_axis_tuser_i
// high when that byte is valid, s_axis_tlast_i on the final beat of a frame
// (a beat with tuser low and tlast high ends an empty frame).
// master channel: one result beat per frame carrying status, the last
// varint of field 1 and the offset and length of field 2.
// a beat waits in the input register while the core works out the next
// parse state; when the beat advances, the state register updates and, if it
// was the last beat, the result register loads: a last beat passes the input
// register and then the result register before its result is valid.
// throughput is one beat per cycle, unless a last beat waits for the result slot.
// reset clears the parse state and the input and result valid flags;
// each frame end returns the parse state to its reset value.
// while a result waits, beats that are not last keep flowing; a last beat
// waits in the input register until the result slot frees, and the slave
// channel stalls behind it.
module protobuf_field_stream_decoder_unit import pfsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] data_byte
  input  logic               s_axis_tuser_i,   // [0] has_byte
  input  logic               s_axis_tlast_i,   // frame_end
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o    // [1:0] status, [33:2] first_value,
                                               // [34] second_present,
                                               // [43:35] second_offset,
                                               // [53:44] second_length, rest zero
);

  logic         in_vld_q;
  logic [7:0]   in_byte_q;
  logic         in_has_q;
  logic         in_last_q;
  parse_state_t state_q, state_d;
  result_t      res_d, res_q;
  logic         out_vld_q;
  logic         advance;

  assign advance         = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  pfsd_core u_core (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .has_i    (in_has_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_has_q  <= s_axis_tuser_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(TDATA_W - RES_W)'(0), res_q};

`ifndef SYNTH
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_vld_q && in_last_q))
    else $error("result beat without a last input beat");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (state_q.pos == '0 && state_q.phase == PH_TAG))
    else $error("parse state not cleared after frame end");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos <= POS_W'(MAX_PAYLOAD))
    else $error("byte position beyond payload limit");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.err != ST_OK && !(advance && in_last_q)) |=> $stable(state_q.err))
    else $error("latched error changed within a frame");
`endif

endmodule
